// ----- hw/rtl/btk_pkg.sv -----
// Package for the bounded top-k min-heap: element type, sizes and the ranking
// function. No dependencies.
package btk_pkg;

  localparam int HEAP_DEPTH = 32;
  localparam int IDX_W      = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int KID_W      = IDX_W + 2;
  localparam int CMP_W      = ((CNT_W > 6) ? CNT_W : 6) + 1;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] len;
    logic [31:0] sid;
  } elem_t;

  localparam elem_t ELEM_ZERO = '{cnt: 32'd0, len: 32'd0, sid: 32'd0};

  // true if a ranks worse than b
  function automatic logic worse(elem_t a, elem_t b);
    logic r;
    if (a.cnt != b.cnt) r = (a.cnt < b.cnt);
    else if (a.len != b.len) r = (a.len > b.len);
    else r = (a.sid > b.sid);
    return r;
  endfunction

endpackage

// ----- hw/rtl/btk_if.sv -----
// Channel interfaces for request, result and configuration beats.
// Depends on btk_pkg.
interface btk_req_if import btk_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] hit_count;
  logic [31:0] target_length;
  logic [31:0] target_id;
  modport source (output valid, req_type, hit_count, target_length, target_id, input ready);
  modport sink   (input valid, req_type, hit_count, target_length, target_id, output ready);
endinterface

interface btk_res_if import btk_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] out_count;
  logic [31:0] out_length;
  logic [31:0] out_id;
  logic        was_empty;
  logic [5:0]  occupancy;
  modport source (output valid, out_count, out_length, out_id, was_empty, occupancy,
                  input ready);
  modport sink   (input valid, out_count, out_length, out_id, was_empty, occupancy,
                  output ready);
endinterface

interface btk_cfg_if ();
  logic       valid;
  logic       ready;
  logic [5:0] keep_limit;
  modport source (output valid, keep_limit, input ready);
  modport sink   (input valid, keep_limit, output ready);
endinterface

// ----- hw/rtl/bounded_top_k_min_heap.sv -----
// Bounded top-k keeper on a binary min-heap held in one synchronous RAM.
// Clear needs no RAM access and an add into an empty heap writes the root; other adds
// climb level by level, or when full and the root ranks worse replace the root and sift
// down; a pop reads each held entry once for the best and sifts the last into its place.
// One request at a time; the single RAM read port sets the pace. Result is held in an output
// register so the next request is taken while it waits. Reset (synchronous, active low)
// empties the heap and sets keep_limit to 32; RAM contents are not cleared.
module bounded_top_k_min_heap import btk_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  btk_req_if.sink      in_if,
  btk_res_if.source    out_if,
  btk_cfg_if.sink      cfg_if
);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_CMP, S_UP_FIN, S_ROOT_CMP, S_DN_START, S_DN_K0, S_DN_K1, S_DN_CMP,
    S_SCAN, S_POP_FIX, S_POP_MV, S_POP_PAR, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt, kid_r, kid_nxt, bidx_r, bidx_nxt, scan_r, scan_nxt;
  elem_t              e_r, e_nxt, kd_r, kd_nxt, best_r, best_nxt, res_r, res_nxt;
  logic               empty_r, empty_nxt;
  logic [5:0]         keep_limit_r;
  logic               out_valid_r;
  elem_t              out_el_r;
  logic               out_empty_r;
  logic [5:0]         out_occ_r;

  // heap RAM
  logic [$bits(elem_t)-1:0] mem [HEAP_DEPTH];
  logic                     we, re;
  logic [IDX_W-1:0]         waddr, raddr;
  elem_t                    wdata, rd;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd <= mem[raddr];
  end

  logic [CMP_W-1:0] lim, cap;
  logic             room, accept;
  logic [IDX_W-1:0] up;
  logic [KID_W-1:0] kid, fill_k;

  assign lim    = CMP_W'(keep_limit_r);
  assign cap    = (lim > CMP_W'(HEAP_DEPTH)) ? CMP_W'(HEAP_DEPTH) : lim;
  assign room   = CMP_W'(fill_r) < cap;
  assign accept = in_if.valid && in_if.ready;
  assign up     = IDX_W'((pos_r - 1'b1) >> 1);
  assign kid    = {1'b0, pos_r, 1'b1};
  assign fill_k = KID_W'(fill_r);

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.out_count  = out_el_r.cnt;
  assign out_if.out_length = out_el_r.len;
  assign out_if.out_id     = out_el_r.sid;
  assign out_if.was_empty  = out_empty_r;
  assign out_if.occupancy  = out_occ_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    pos_nxt   = pos_r;
    kid_nxt   = kid_r;
    bidx_nxt  = bidx_r;
    scan_nxt  = scan_r;
    e_nxt     = e_r;
    kd_nxt    = kd_r;
    best_nxt  = best_r;
    res_nxt   = res_r;
    empty_nxt = empty_r;
    we = 1'b0;  waddr = pos_r;  wdata = e_r;
    re = 1'b0;  raddr = up;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt   = ELEM_ZERO;
          empty_nxt = 1'b0;
          state_nxt = S_DONE;
          e_nxt = '{cnt: in_if.hit_count, len: in_if.target_length, sid: in_if.target_id};
          case (in_if.req_type)
            REQ_ADD: begin
              if (room) begin
                fill_nxt = fill_r + 1'b1;
                pos_nxt  = IDX_W'(fill_r);
                if (fill_r == '0) begin
                  we = 1'b1;  waddr = '0;  wdata = e_nxt;
                end else begin
                  re = 1'b1;  raddr = IDX_W'((fill_r - 1'b1) >> 1);
                  state_nxt = S_UP_CMP;
                end
              end else if (fill_r != '0) begin
                re = 1'b1;  raddr = '0;
                state_nxt = S_ROOT_CMP;
              end
            end
            REQ_POP: begin
              if (fill_r == '0) begin
                empty_nxt = 1'b1;
              end else begin
                re = 1'b1;  raddr = '0;
                scan_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            REQ_CLEAR: fill_nxt = '0;
            default: ;
          endcase
        end
      end
      S_UP_CMP, S_POP_PAR: begin
        if (worse(e_r, rd)) begin
          we = 1'b1;  waddr = pos_r;  wdata = rd;
          pos_nxt = up;
          if (up == '0) begin
            state_nxt = S_UP_FIN;
          end else begin
            re = 1'b1;  raddr = IDX_W'((up - 1'b1) >> 1);
            state_nxt = S_UP_CMP;
          end
        end else if (state_r == S_POP_PAR) begin
          state_nxt = S_DN_START;
        end else begin
          we = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_UP_FIN: begin
        we = 1'b1;
        state_nxt = S_DONE;
      end
      S_ROOT_CMP: begin
        if (worse(rd, e_r)) begin
          pos_nxt   = '0;
          state_nxt = S_DN_START;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DN_START: begin
        if (kid < fill_k) begin
          re = 1'b1;  raddr = IDX_W'(kid);
          kid_nxt   = IDX_W'(kid);
          state_nxt = S_DN_K0;
        end else begin
          we = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DN_K0: begin
        kd_nxt = rd;
        if (KID_W'(kid_r) + 1'b1 < fill_k) begin
          re = 1'b1;  raddr = kid_r + 1'b1;
          state_nxt = S_DN_K1;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_K1: begin
        if (worse(rd, kd_r)) begin
          kd_nxt  = rd;
          kid_nxt = kid_r + 1'b1;
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (worse(kd_r, e_r)) begin
          wdata     = kd_r;
          pos_nxt   = kid_r;
          state_nxt = S_DN_START;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_r == '0 || worse(best_r, rd)) begin
          best_nxt = rd;
          bidx_nxt = scan_r;
        end
        if (CNT_W'(scan_r) + 1'b1 < fill_r) begin
          re = 1'b1;  raddr = scan_r + 1'b1;
          scan_nxt = scan_r + 1'b1;
        end else begin
          state_nxt = S_POP_FIX;
        end
      end
      S_POP_FIX: begin
        res_nxt  = best_r;
        fill_nxt = fill_r - 1'b1;
        if (CNT_W'(bidx_r) < fill_nxt) begin
          re = 1'b1;  raddr = IDX_W'(fill_nxt);
          state_nxt = S_POP_MV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POP_MV: begin
        e_nxt   = rd;
        pos_nxt = bidx_r;
        if (bidx_r != '0) begin
          re = 1'b1;  raddr = IDX_W'((bidx_r - 1'b1) >> 1);
          state_nxt = S_POP_PAR;
        end else begin
          state_nxt = S_DN_START;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      keep_limit_r <= 6'd32;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (cfg_if.valid) keep_limit_r <= cfg_if.keep_limit;
      if (state_r == S_DONE && (!out_valid_r || out_if.ready)) begin
        out_valid_r <= 1'b1;
        out_el_r    <= res_r;
        out_empty_r <= empty_r;
        out_occ_r   <= 6'(fill_r);
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    pos_r   <= pos_nxt;
    kid_r   <= kid_nxt;
    bidx_r  <= bidx_nxt;
    scan_r  <= scan_nxt;
    e_r     <= e_nxt;
    kd_r    <= kd_nxt;
    best_r  <= best_nxt;
    res_r   <= res_nxt;
    empty_r <= empty_nxt;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(fill_r) <= CNT_W'(HEAP_DEPTH))
    else $error("fill above depth");
  a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (CNT_W'(waddr) < fill_nxt))
    else $error("heap write outside held entries");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_occ_r == 6'd0 && out_el_r == ELEM_ZERO))
    else $error("empty pop with data");
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_if.ready)
    else $error("request taken while busy");

endmodule

// ----- test/bounded_top_k_min_heap_check.sv -----
`timescale 1ns / 1ps
// Checker for the bounded top-k min-heap: watches request, result and config beats,
// keeps its own heap and compares each result beat. Depends on btk_pkg and btk_if.
module bounded_top_k_min_heap_check import btk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  btk_req_if.sink   in_mon,
  btk_res_if.sink   out_mon,
  btk_cfg_if.sink   cfg_mon,
  output int        fail_count,
  output int        pending,
  output int        pops_seen,
  output int        empty_pops
);

  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] len;
    logic [31:0] sid;
    logic        empty;
    logic [5:0]  occ;
  } heap_res_t;

  elem_t       heap_q[HEAP_DEPTH];
  int unsigned held;
  logic [5:0]  limit;
  heap_res_t   expected_res[$];

  function automatic logic ranks_below(elem_t a, elem_t b);
    if (a.cnt != b.cnt) return a.cnt < b.cnt;
    if (a.len != b.len) return a.len > b.len;
    return a.sid > b.sid;
  endfunction

  task automatic climb(int unsigned pos, elem_t e);
    int unsigned up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!ranks_below(e, heap_q[up])) break;
      heap_q[pos] = heap_q[up];
      pos = up;
    end
    heap_q[pos] = e;
  endtask

  task automatic sink_down(int unsigned pos, elem_t e);
    int unsigned kid;
    kid = 2 * pos + 1;
    while (kid < held) begin
      if (kid + 1 < held && ranks_below(heap_q[kid + 1], heap_q[kid])) kid++;
      if (!ranks_below(heap_q[kid], e)) break;
      heap_q[pos] = heap_q[kid];
      pos = kid;
      kid = 2 * pos + 1;
    end
    heap_q[pos] = e;
  endtask

  task automatic apply_request(logic [1:0] rt, elem_t e);
    heap_res_t   r;
    int unsigned cap, best;
    elem_t       moved;
    r = '0;
    cap = (limit > HEAP_DEPTH) ? HEAP_DEPTH : limit;
    if (rt == REQ_ADD) begin
      if (held < cap) begin
        held++;
        climb(held - 1, e);
      end else if (held > 0 && ranks_below(heap_q[0], e)) begin
        sink_down(0, e);
      end
    end else if (rt == REQ_POP) begin
      pops_seen++;
      if (held == 0) begin
        r.empty = 1'b1;
        empty_pops++;
      end else begin
        best = 0;
        for (int unsigned i = 1; i < held; i++)
          if (ranks_below(heap_q[best], heap_q[i])) best = i;
        r.cnt = heap_q[best].cnt;
        r.len = heap_q[best].len;
        r.sid = heap_q[best].sid;
        held--;
        if (best < held) begin
          moved = heap_q[held];
          if (best > 0 && ranks_below(moved, heap_q[(best - 1) / 2])) climb(best, moved);
          else sink_down(best, moved);
        end
      end
    end else if (rt == REQ_CLEAR) begin
      held = 0;
    end
    r.occ = held[5:0];
    expected_res = {expected_res, r};
  endtask

  always @(posedge clk) begin
    heap_res_t exp_r, got;
    if (!rst_n) begin
      held = 0;
      limit = 6'd32;
      fail_count = 0;
      pops_seen = 0;
      empty_pops = 0;
      expected_res.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) limit = cfg_mon.keep_limit;
      if (in_mon.valid && in_mon.ready)
        apply_request(in_mon.req_type,
                      '{cnt: in_mon.hit_count, len: in_mon.target_length,
                        sid: in_mon.target_id});
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.out_count, out_mon.out_length, out_mon.out_id,
                out_mon.was_empty, out_mon.occupancy};
        if (expected_res.size() == 0) begin
          $display("%0t: unexpected result beat, actual %h", $time, got);
          fail_count++;
        end else begin
          exp_r = expected_res.pop_front();
          if (got.cnt !== exp_r.cnt)
            $display("%0t: out_count expected %h actual %h", $time, exp_r.cnt, got.cnt);
          if (got.len !== exp_r.len)
            $display("%0t: out_length expected %h actual %h", $time, exp_r.len, got.len);
          if (got.sid !== exp_r.sid)
            $display("%0t: out_id expected %h actual %h", $time, exp_r.sid, got.sid);
          if (got.empty !== exp_r.empty)
            $display("%0t: was_empty expected %b actual %b", $time, exp_r.empty, got.empty);
          if (got.occ !== exp_r.occ)
            $display("%0t: occupancy expected %0d actual %0d", $time, exp_r.occ, got.occ);
          if (got !== exp_r) fail_count++;
        end
      end
    end
    pending = expected_res.size();
  end

endmodule

// ----- test/bounded_top_k_min_heap_test.sv -----
`timescale 1ns / 1ps
// Top of the bounded top-k min-heap testbench: clock, reset, request and config stimulus,
// receiver stalls and verdict. Depends on btk_pkg, btk_if, the checker and the block.
module bounded_top_k_min_heap_test import btk_pkg::*; ;

  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n;
  int   fail_count, pending, pops_seen, empty_pops;
  int   idle_cycles, beats_sent, long_hold;

  btk_req_if in_if ();
  btk_res_if out_if ();
  btk_cfg_if cfg_if ();

  bounded_top_k_min_heap dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  bounded_top_k_min_heap_check checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_if.sink), .out_mon(out_if.sink),
    .cfg_mon(cfg_if.sink), .fail_count(fail_count), .pending(pending),
    .pops_seen(pops_seen), .empty_pops(empty_pops)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = REQ_ADD;
    in_if.hit_count = '0;
    in_if.target_length = '0;
    in_if.target_id = '0;
    cfg_if.valid = 1'b0;
    cfg_if.keep_limit = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // watchdog on cycles with no beat
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random gaps, one long hold-off when asked
  initial begin
    int gap;
    bit hold_done;
    out_if.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold > 0 && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (long_hold) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  task automatic send_req(logic [1:0] rt, logic [31:0] c, logic [31:0] l, logic [31:0] s,
                          bit no_gap = 0);
    int gap;
    gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= rt;
    in_if.hit_count <= c;
    in_if.target_length <= l;
    in_if.target_id <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [5:0] v);
    drain_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.keep_limit <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int n, int pop_weight);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < pop_weight) send_req(REQ_POP, $urandom(), $urandom(), $urandom());
      else if (r < pop_weight + 2) send_req(REQ_CLEAR, $urandom(), $urandom(), $urandom());
      else if (r < pop_weight + 3) send_req(2'd3, $urandom(), $urandom(), $urandom());
      else send_req(REQ_ADD, pick_key(), pick_key(), pick_key());
    end
  endtask

  initial begin
    logic [5:0] limits[6];
    beats_sent = 0;
    long_hold = 0;
    limits = '{6'd5, 6'd1, 6'd63, 6'd17, 6'd0, 6'd32};
    @(posedge clk iff rst_n);
    @(posedge clk);
    // directed: extremes, ties, each request code
    send_req(REQ_POP, '1, '1, '1);
    send_req(REQ_ADD, '0, '0, '0);
    send_req(REQ_ADD, '1, '1, '1);
    send_req(REQ_ADD, '1, '0, '1);
    send_req(REQ_ADD, '1, '0, '0);
    send_req(REQ_ADD, 32'd5, 32'd9, 32'd3);
    send_req(REQ_ADD, 32'd5, 32'd9, 32'd3);
    send_req(REQ_ADD, 32'd5, 32'd9, 32'd2);
    send_req(2'd3, '1, '1, '1);
    repeat (8) send_req(REQ_POP, '0, '0, '0);
    send_req(REQ_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_POP, '0, '0, '0);
    // limit of 2, then lowered below fill
    write_limit(6'd2);
    repeat (4) send_req(REQ_ADD, pick_key(), pick_key(), pick_key());
    write_limit(6'd32);
    repeat (20) send_req(REQ_ADD, pick_key(), pick_key(), pick_key());
    write_limit(6'd3);
    repeat (6) send_req(REQ_ADD, pick_key(), pick_key(), pick_key());
    // fill to the top, then hold the receiver off while adds keep coming
    write_limit(6'd32);
    send_req(REQ_CLEAR, '0, '0, '0);
    long_hold = 400;
    for (int i = 0; i < 40; i++)
      send_req(REQ_ADD, $urandom(), $urandom(), $urandom(), 1);
    random_phase(200, 30);
    foreach (limits[k]) begin
      write_limit(limits[k]);
      random_phase(110, (k % 2) ? 45 : 25);
    end
    drain_idle();
    $display("Sent %0d request beats over limits 0 to 63; %0d pops, %0d on an empty heap.",
             beats_sent, pops_seen, empty_pops);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/btk_pkg.sv
hw/rtl/btk_if.sv
hw/rtl/bounded_top_k_min_heap.sv
test/bounded_top_k_min_heap_check.sv
test/bounded_top_k_min_heap_test.sv
